### hdl/bounded_stack_with_average_defines.svh
// ----------------------------------------------------------------------------
// bounded stack with average: assertion macros
// shared property forms for the checks in the rtl
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_AVERAGE_DEFINES_SVH
`define BOUNDED_STACK_WITH_AVERAGE_DEFINES_SVH

// same-cycle implication under reset
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// types, codes and constants of the bounded stack with average
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int WEIGHT_W  = 14;
  localparam int COUNT_W   = 4;
  localparam int DEPTH_DEF = 12;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 14'd10000;

  localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);
  localparam int SUM_W_DEF = $clog2(DEPTH_DEF * 10000 + 1);

  // request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [WEIGHT_W-1:0] weight;
  } bsa_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [WEIGHT_W-1:0] popped_weight;
    logic [WEIGHT_W-1:0] top_weight;
    logic [COUNT_W-1:0]  item_count;
    logic [WEIGHT_W-1:0] average_weight;
  } bsa_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } bsa_cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV
  } bsa_state_t;

endpackage

### hdl/bounded_stack_with_average.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_average
// bounded lifo of weights with running sum and truncated average
// ----------------------------------------------------------------------------
// A request beat (push, pop or clear) is taken on a rising edge with start
// high and busy low. The stack is a row of DEPTH cells that all shift down on
// a push and up on a pop, so the top always sits in the first cell; the count
// and running sum update on that same edge. A refused push or pop changes
// nothing and reports its status.
// The average comes from a restoring divider giving one quotient bit a cycle
// over the sum width (17 bits at the default depth). A result beat appears on
// out_res for one cycle with out_valid high once the request has gone through
// S_LOAD and the divide in S_DIV; busy falls in that same cycle, and no new
// request is taken before it. The result beat cannot be held off: the
// receiver must take it.
// Reset (rst_n low, synchronous) empties the stack and clears the sum; cell
// contents are not cleared and are never read above the count.
// ----------------------------------------------------------------------------
`include "bounded_stack_with_average_defines.svh"

module bounded_stack_with_average import bsa_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bsa_in_t  in_req,
  output logic     out_valid,
  output bsa_out_t out_res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = $clog2(DEPTH * 10000 + 1);

  bsa_state_t state_r, state_nxt;
  logic       accept;
  logic       div_start;
  logic       div_done;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [WEIGHT_W-1:0] popped_r, popped_nxt;
  logic                out_valid_r, out_valid_nxt;
  bsa_out_t            out_r, out_nxt;

  logic [WEIGHT_W-1:0] w_sat;
  logic [SUM_W-1:0]    quotient;
  bsa_cell_ctrl_t      cell_ctrl;
  logic [WEIGHT_W-1:0] slot [DEPTH];

  assign accept = start && (state_r == S_IDLE);
  assign w_sat  = (in_req.weight > WEIGHT_MAX) ? WEIGHT_MAX : in_req.weight;

  // stack cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WEIGHT_W-1:0] above;
    logic [WEIGHT_W-1:0] below;
    if (i == 0) begin : g_first
      assign above = w_sat;
    end else begin : g_mid
      assign above = slot[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = slot[i];
    end else begin : g_rest
      assign below = slot[i+1];
    end
    bsa_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .from_above (above),
      .from_below (below),
      .value      (slot[i])
    );
  end

  // request decode
  always_comb begin
    cell_ctrl  = '0;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    if (accept) begin
      status_nxt = ST_DONE;
      popped_nxt = '0;
      case (in_req.req_type)
        REQ_PUSH: begin
          if (count_r >= CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            cell_ctrl.push = 1'b1;
            count_nxt      = count_r + 1'b1;
            sum_nxt        = sum_r + SUM_W'(w_sat);
          end
        end
        REQ_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            cell_ctrl.pop = 1'b1;
            count_nxt     = count_r - 1'b1;
            sum_nxt       = sum_r - SUM_W'(slot[0]);
            popped_nxt    = slot[0];
          end
        end
        REQ_CLEAR: begin
          count_nxt = '0;
          sum_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt              = S_IDLE;
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.popped_weight  = popped_r;
          out_nxt.item_count     = COUNT_W'(count_r);
          out_nxt.top_weight     = (count_r == '0) ? '0 : slot[0];
          out_nxt.average_weight = (count_r == '0) ? '0 : WEIGHT_W'(quotient);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    out_r    <= out_nxt;
  end

  bsa_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `BSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "request beat did not raise busy")
  `BSA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "count beyond depth")
  `BSA_ASSERT_NOW(a_done_in_div, clk, rst_n, div_done, state_r == S_DIV, "divider done outside divide")
  `BSA_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid_r, !busy, "result beat while busy")
  `BSA_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid_r && count_r == '0,
    out_r.top_weight == '0 && out_r.average_weight == '0, "empty stack reports nonzero")

endmodule

### hdl/bsa_cell.sv
// ----------------------------------------------------------------------------
// bsa_cell
// one stack slot: takes its upper neighbour on push, its lower one on pop
// ----------------------------------------------------------------------------
module bsa_cell import bsa_pkg::*; (
  input  logic                clk,
  input  bsa_cell_ctrl_t      ctrl,
  input  logic [WEIGHT_W-1:0] from_above,
  input  logic [WEIGHT_W-1:0] from_below,
  output logic [WEIGHT_W-1:0] value
);

  logic [WEIGHT_W-1:0] value_r;
  logic [WEIGHT_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push) begin
      value_nxt = from_above;
    end else if (ctrl.pop) begin
      value_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### hdl/bsa_div.sv
// ----------------------------------------------------------------------------
// bsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsa_div import bsa_pkg::*; #(
  parameter int NUM_W = SUM_W_DEF,
  parameter int DEN_W = CNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic              active_r, active_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_shift;
  logic              fits;

  always_comb begin
    rem_shift = {rem_r, num_r[NUM_W-1]};
    fits      = rem_shift >= {1'b0, den_r};
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    if (start) begin
      active_nxt = 1'b1;
      step_nxt   = '0;
      num_nxt    = dividend;
      rem_nxt    = '0;
      den_nxt    = divisor;
    end else if (active_r) begin
      // quotient bits shift in as dividend bits shift out
      num_nxt  = {num_r[NUM_W-2:0], fits};
      rem_nxt  = fits ? DEN_W'(rem_shift - {1'b0, den_r}) : rem_shift[DEN_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(NUM_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

### sim/bounded_stack_with_average_tb.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_average_tb
// self-checking bench for the bounded weight stack with running average
// ----------------------------------------------------------------------------
// Request beats are queued up front by an initial block. They open with a
// directed run through the empty, full, saturating and unused-code cases and
// go on to random blocks that lean to pushes, to pops or to neither, so that the
// stack fills and empties many times. A clocked driver presents the beats with
// random gaps and models the stack as each beat is taken. A clocked monitor
// compares every result beat, field by field, with the oldest predicted report.
// ----------------------------------------------------------------------------
module bounded_stack_with_average_tb;
  import bsa_pkg::*;

  localparam logic [1:0] REQ_NONE     = 2'd3;  // unused code, acts as a no-op
  localparam int         RANDOM_BEATS = 810;
  localparam int         TAIL_CYCLES  = 60;
  localparam int         CYCLE_LIMIT  = 400000;

  typedef struct {
    bsa_in_t     req;
    int unsigned gap;
    bit          drain_first;  // hold until every report is back
  } stim_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  bsa_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  bsa_out_t out_res;

  stim_t    request_queue[$];
  bsa_out_t pending_reports[$];

  // shadow of the stack
  logic [WEIGHT_W-1:0] stack_mem[DEPTH_DEF];
  int unsigned         depth_used = 0;
  int unsigned         weight_total = 0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  bit          gap_loaded = 1'b0;
  bit          burst_mode = 1'b0;

  bounded_stack_with_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow stack and return the report it gives
  function automatic bsa_out_t apply_request(bsa_in_t req);
    bsa_out_t            rep;
    logic [WEIGHT_W-1:0] w;
    rep = '0;
    rep.status = ST_DONE;
    w = (req.weight > WEIGHT_MAX) ? WEIGHT_MAX : req.weight;
    case (req.req_type)
      REQ_PUSH: begin
        if (depth_used >= DEPTH_DEF) begin
          rep.status = ST_FULL;
        end else begin
          stack_mem[depth_used] = w;
          depth_used++;
          weight_total += w;
        end
      end
      REQ_POP: begin
        if (depth_used == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          depth_used--;
          rep.popped_weight = stack_mem[depth_used];
          weight_total -= stack_mem[depth_used];
        end
      end
      REQ_CLEAR: begin
        depth_used = 0;
        weight_total = 0;
      end
      default: ;
    endcase
    if (depth_used > 0) begin
      rep.top_weight = stack_mem[depth_used - 1];
      rep.average_weight = WEIGHT_W'(weight_total / depth_used);
    end
    rep.item_count = COUNT_W'(depth_used);
    return rep;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return WEIGHT_W'($urandom_range(0, 10000));
    if (r < 93) return WEIGHT_W'($urandom_range(10001, 16383));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return WEIGHT_MAX;
      2: return '1;
      default: return WEIGHT_W'(1) << $urandom_range(0, WEIGHT_W - 1);
    endcase
  endfunction

  task automatic add_req(logic [1:0] code, logic [WEIGHT_W-1:0] w, bit drain);
    stim_t s;
    s.req.req_type = code;
    s.req.weight = w;
    s.gap = pick_gap();
    s.drain_first = drain;
    request_queue.push_back(s);
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // driver: a beat is taken on an edge with start high and busy low
  always @(posedge clk) begin
    stim_t   head;
    logic    next_start;
    bsa_in_t next_req;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      next_req = in_req;
      if (start && !busy) begin
        pending_reports.push_back(apply_request(in_req));
        next_start = 1'b0;
        gap_loaded = 1'b0;
      end
      if (!next_start && request_queue.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = request_queue[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!request_queue[0].drain_first || pending_reports.size() == 0) begin
          head = request_queue.pop_front();
          next_start = 1'b1;
          next_req = head.req;
          gap_loaded = 1'b0;
        end
      end
      start <= next_start;
      in_req <= next_req;
    end
  end

  // monitor: result beats cannot be held off, so take each one as it shows
  always @(posedge clk) begin
    bsa_out_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no request waiting");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 16'(want.status), 16'(out_res.status));
        check_field("popped_weight", 16'(want.popped_weight),
                    16'(out_res.popped_weight));
        check_field("top_weight", 16'(want.top_weight), 16'(out_res.top_weight));
        check_field("item_count", 16'(want.item_count), 16'(out_res.item_count));
        check_field("average_weight", 16'(want.average_weight),
                    16'(out_res.average_weight));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned block_len;
    int unsigned push_pct;
    int unsigned r;
    logic [1:0]  code;

    // directed: empty, saturation, unused code, fill to full, refusals, clear
    add_req(REQ_CLEAR, 14'd0, 1'b0);
    add_req(REQ_POP, 14'd0, 1'b0);
    add_req(REQ_NONE, 14'h3FFF, 1'b0);
    add_req(REQ_PUSH, 14'd0, 1'b0);
    add_req(REQ_PUSH, 14'h3FFF, 1'b0);
    add_req(REQ_PUSH, 14'd10000, 1'b0);
    add_req(REQ_PUSH, 14'd10001, 1'b0);
    add_req(REQ_NONE, 14'd0, 1'b0);
    add_req(REQ_POP, 14'h3FFF, 1'b0);
    add_req(REQ_PUSH, 14'h1555, 1'b0);
    add_req(REQ_PUSH, 14'h2AAA, 1'b0);
    add_req(REQ_PUSH, 14'd1, 1'b0);
    add_req(REQ_PUSH, 14'd9999, 1'b0);
    add_req(REQ_PUSH, 14'd5000, 1'b0);
    add_req(REQ_PUSH, 14'd7, 1'b0);
    add_req(REQ_PUSH, 14'd10000, 1'b0);
    add_req(REQ_PUSH, 14'd123, 1'b0);
    add_req(REQ_PUSH, 14'd4096, 1'b0);
    add_req(REQ_PUSH, 14'h3FFF, 1'b0);
    add_req(REQ_POP, 14'd0, 1'b0);
    add_req(REQ_POP, 14'd0, 1'b0);
    add_req(REQ_CLEAR, 14'h3FFF, 1'b0);
    add_req(REQ_POP, 14'd0, 1'b0);
    add_req(REQ_PUSH, 14'd10000, 1'b0);
    add_req(REQ_POP, 14'd0, 1'b0);

    // random blocks, each leaning towards filling or draining the stack or neither
    n = 0;
    while (n < RANDOM_BEATS) begin
      block_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < block_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) code = REQ_CLEAR;
        else if (r < 6) code = REQ_NONE;
        else if (r < 6 + push_pct * 94 / 100) code = REQ_PUSH;
        else code = REQ_POP;
        add_req(code, pick_weight(), (n == 0) || (i == 0 && $urandom_range(0, 7) == 0));
        n++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (request_queue.size() != 0 || start || pending_reports.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bsa_pkg.sv
hdl/bsa_cell.sv
hdl/bsa_div.sv
hdl/bounded_stack_with_average.sv
sim/bounded_stack_with_average_tb.sv
